>>> hdl/esrw_pkg.sv
// shared types and constants for the elite set replace-worst block
`default_nettype none
package esrw_pkg;

   localparam int ELITE_DEPTH_DEF = 16;
   localparam int COST_BITS_DEF   = 32;

   localparam int CAP_W      = 5;
   localparam int COST_W     = 32;
   localparam int ID_W       = 16;
   localparam int SLOT_W     = 4;
   localparam int FILL_W     = 5;
   localparam int COUNT_W    = 16;
   localparam int REQ_W      = 2;

   localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   localparam logic [REQ_W-1:0] REQ_OFFER = 2'd0;
   localparam logic [REQ_W-1:0] REQ_MINED = 2'd1;
   localparam logic [REQ_W-1:0] REQ_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVICT,
      ST_SCAN,
      ST_LAST,
      ST_FINISH
   } state_type;

endpackage
`default_nettype wire

>>> hdl/esrw_ram.sv
// generic single write port ram with registered read
`default_nettype none
module esrw_ram #(
   parameter int WIDTH = esrw_pkg::COST_BITS_DEF,
   parameter int DEPTH = esrw_pkg::ELITE_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> hdl/esrw_scan.sv
// shared compare unit that walks the cost table and keeps the worst entry
`default_nettype none
module esrw_scan #(
   parameter int ELITE_DEPTH = esrw_pkg::ELITE_DEPTH_DEF,
   parameter int COST_BITS   = esrw_pkg::COST_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           issue,
   input  wire logic [$clog2(ELITE_DEPTH)-1:0] issue_idx,
   input  wire logic [COST_BITS-1:0]           rd_data,
   output logic      [COST_BITS-1:0]           worst_cost,
   output logic      [$clog2(ELITE_DEPTH)-1:0] worst_idx
);

   localparam int IDX_W = $clog2(ELITE_DEPTH);

   logic             cmp_valid_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic [COST_BITS-1:0] worst_cost_ff, worst_cost_in;
   logic [IDX_W-1:0]     worst_idx_ff, worst_idx_in;

   // ram data arrives in the cycle after the address is issued, so issue and index are registered to match
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
         cmp_idx_ff   <= '0;
      end else begin
         cmp_valid_ff <= issue;
         cmp_idx_ff   <= issue_idx;
      end
   end

   always_comb begin
      worst_cost_in = worst_cost_ff;
      worst_idx_in  = worst_idx_ff;
      if (cmp_valid_ff) begin
         // slot zero seeds the scan, later slots win only on strictly larger cost
         if (cmp_idx_ff == '0 || rd_data > worst_cost_ff) begin
            worst_cost_in = rd_data;
            worst_idx_in  = cmp_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         worst_cost_ff <= '0;
         worst_idx_ff  <= '0;
      end else begin
         worst_cost_ff <= worst_cost_in;
         worst_idx_ff  <= worst_idx_in;
      end
   end

   assign worst_cost = worst_cost_ff;
   assign worst_idx  = worst_idx_ff;

endmodule
`default_nettype wire

>>> hdl/elite_set_replace_worst_top.sv
// elite set with replace-worst policy: sequencer, bookkeeping and result register
// an accepted solution is written (through the evict state when it evicts), then the cost
// ram is rescanned one slot per cycle; the result is loaded once the output is free
// rejected offers and all other requests give their result in the cycle after accept
// a new item is taken only once the previous one has left the sequencer
// synchronous reset empties the set, clears flags and counters, capacity returns to 16
`default_nettype none
module elite_set_replace_worst_top #(
   parameter int ELITE_DEPTH = esrw_pkg::ELITE_DEPTH_DEF,
   parameter int COST_BITS   = esrw_pkg::COST_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [esrw_pkg::CAP_W-1:0]   csr_capacity,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [esrw_pkg::REQ_W-1:0]   req_type,
   input  wire logic [esrw_pkg::COST_W-1:0]  req_cost,
   input  wire logic [esrw_pkg::ID_W-1:0]    req_solution_id,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_accepted,
   output logic      [esrw_pkg::SLOT_W-1:0]  rsp_slot_written,
   output logic                              rsp_evicted_valid,
   output logic      [esrw_pkg::ID_W-1:0]    rsp_evicted_id,
   output logic      [esrw_pkg::COST_W-1:0]  rsp_worst_cost,
   output logic      [esrw_pkg::SLOT_W-1:0]  rsp_worst_slot,
   output logic      [esrw_pkg::FILL_W-1:0]  rsp_fill_count,
   output logic      [esrw_pkg::COUNT_W-1:0] rsp_no_change_count,
   output logic                              rsp_changed_flag,
   output logic                              rsp_mined_flag,
   output logic      [esrw_pkg::COUNT_W-1:0] rsp_mine_count
);

   localparam int IDX_W = $clog2(ELITE_DEPTH);
   localparam int CNT_W = $clog2(ELITE_DEPTH + 1);
   localparam int EW    = (CNT_W > esrw_pkg::CAP_W) ? CNT_W : esrw_pkg::CAP_W;
   localparam int ID_W  = esrw_pkg::ID_W;
   localparam int CW    = esrw_pkg::COUNT_W;

   esrw_pkg::state_type state_ff, state_in;

   logic [esrw_pkg::CAP_W-1:0] capacity_ff;
   logic [CNT_W-1:0]     occupied_ff, occupied_in;
   logic [CW-1:0]        stall_ff, stall_in;
   logic                 changed_ff, changed_in;
   logic                 mined_ff, mined_in;
   logic [CW-1:0]        runs_ff, runs_in;
   logic [IDX_W-1:0]     scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic                 ev_ff, ev_in;
   logic [ID_W-1:0]      evid_ff, evid_in;
   logic [COST_BITS-1:0] cost_ff, cost_in;
   logic [ID_W-1:0]      id_ff, id_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         acc_ff;
   logic [esrw_pkg::SLOT_W-1:0]  slotw_ff;
   logic                         evv_ff;
   logic [ID_W-1:0]              evido_ff;
   logic [esrw_pkg::COST_W-1:0]  wcost_ff;
   logic [esrw_pkg::SLOT_W-1:0]  wslot_ff;
   logic [esrw_pkg::FILL_W-1:0]  fill_ff;
   logic [CW-1:0]                ncc_ff;
   logic                         chg_ff;
   logic                         mnd_ff;
   logic [CW-1:0]                mcnt_ff;

   logic                 req_fire;
   logic                 out_free;
   logic                 out_load;
   logic                 finish;
   logic [COST_BITS-1:0] cost_req;
   logic [EW-1:0]        cap_ext;
   logic [EW-1:0]        eff_cap;
   logic                 not_full;
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [COST_BITS-1:0] ram_wcost;
   logic [ID_W-1:0]      ram_wid;
   logic [COST_BITS-1:0] cost_rdata;
   logic [ID_W-1:0]      id_rdata;
   logic                 scan_issue;
   logic [COST_BITS-1:0] worst_cost;
   logic [IDX_W-1:0]     worst_idx;
   logic                 scan_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == esrw_pkg::ST_IDLE && out_free);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = (state_ff == esrw_pkg::ST_IDLE);
   assign finish    = (state_ff == esrw_pkg::ST_FINISH);

   assign cost_req = COST_BITS'(req_cost);

   // capacity zero acts as one, anything above the table depth as the depth
   always_comb begin
      cap_ext = EW'(capacity_ff);
      if (cap_ext == '0) begin
         eff_cap = EW'(1);
      end else if (cap_ext > EW'(ELITE_DEPTH)) begin
         eff_cap = EW'(ELITE_DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign not_full  = EW'(occupied_ff) < eff_cap;
   assign scan_last = CNT_W'(scan_idx_ff) == (occupied_ff - CNT_W'(1));

   esrw_ram #(.WIDTH(COST_BITS), .DEPTH(ELITE_DEPTH)) u_cost_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wcost),
      .raddr (scan_idx_ff),
      .rdata (cost_rdata)
   );

   esrw_ram #(.WIDTH(ID_W), .DEPTH(ELITE_DEPTH)) u_id_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wid),
      .raddr (worst_idx),
      .rdata (id_rdata)
   );

   esrw_scan #(.ELITE_DEPTH(ELITE_DEPTH), .COST_BITS(COST_BITS)) u_scan (
      .clock      (clock),
      .reset      (reset),
      .issue      (scan_issue),
      .issue_idx  (scan_idx_ff),
      .rd_data    (cost_rdata),
      .worst_cost (worst_cost),
      .worst_idx  (worst_idx)
   );

   always_comb begin
      state_in    = state_ff;
      occupied_in = occupied_ff;
      stall_in    = stall_ff;
      changed_in  = changed_ff;
      mined_in    = mined_ff;
      runs_in     = runs_ff;
      scan_idx_in = scan_idx_ff;
      slot_in     = slot_ff;
      ev_in       = ev_ff;
      evid_in     = evid_ff;
      cost_in     = cost_ff;
      id_in       = id_ff;
      ram_we      = 1'b0;
      ram_waddr   = IDX_W'(occupied_ff);
      ram_wcost   = cost_req;
      ram_wid     = req_solution_id;
      scan_issue  = 1'b0;
      out_load    = 1'b0;

      case (state_ff)
         esrw_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_type)
                  esrw_pkg::REQ_OFFER: begin
                     if (not_full) begin
                        // free slot: write straight in, then rescan
                        ram_we      = 1'b1;
                        slot_in     = IDX_W'(occupied_ff);
                        occupied_in = occupied_ff + CNT_W'(1);
                        ev_in       = 1'b0;
                        evid_in     = '0;
                        changed_in  = 1'b1;
                        mined_in    = 1'b0;
                        stall_in    = '0;
                        scan_idx_in = '0;
                        state_in    = esrw_pkg::ST_SCAN;
                     end else if (cost_req < worst_cost) begin
                        // id ram is already addressed at the worst slot
                        slot_in    = worst_idx;
                        ev_in      = 1'b1;
                        cost_in    = cost_req;
                        id_in      = req_solution_id;
                        changed_in = 1'b1;
                        mined_in   = 1'b0;
                        stall_in   = '0;
                        state_in   = esrw_pkg::ST_EVICT;
                     end else begin
                        if ((stall_ff != '0 || changed_ff) && stall_ff != esrw_pkg::COUNT_MAX) begin
                           stall_in = stall_ff + CW'(1);
                        end
                        out_load = 1'b1;
                     end
                  end
                  esrw_pkg::REQ_MINED: begin
                     changed_in = 1'b0;
                     stall_in   = '0;
                     mined_in   = 1'b1;
                     runs_in    = runs_ff + CW'(1);
                     out_load   = 1'b1;
                  end
                  esrw_pkg::REQ_EMPTY: begin
                     changed_in = 1'b1;
                     mined_in   = 1'b0;
                     if (runs_ff != '0) begin
                        runs_in = runs_ff - CW'(1);
                     end
                     out_load = 1'b1;
                  end
                  default: begin
                     out_load = 1'b1;
                  end
               endcase
            end
         end
         esrw_pkg::ST_EVICT: begin
            ram_we      = 1'b1;
            ram_waddr   = slot_ff;
            ram_wcost   = cost_ff;
            ram_wid     = id_ff;
            evid_in     = id_rdata;
            scan_idx_in = '0;
            state_in    = esrw_pkg::ST_SCAN;
         end
         esrw_pkg::ST_SCAN: begin
            scan_issue = 1'b1;
            if (scan_last) begin
               state_in = esrw_pkg::ST_LAST;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         esrw_pkg::ST_LAST: begin
            // last compare lands in the scan unit this cycle
            state_in = esrw_pkg::ST_FINISH;
         end
         esrw_pkg::ST_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = esrw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = esrw_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= esrw_pkg::ST_IDLE;
         capacity_ff  <= esrw_pkg::CAP_RESET;
         occupied_ff  <= '0;
         stall_ff     <= '0;
         changed_ff   <= 1'b0;
         mined_ff     <= 1'b0;
         runs_ff      <= '0;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occupied_ff  <= occupied_in;
         stall_ff     <= stall_in;
         changed_ff   <= changed_in;
         mined_ff     <= mined_in;
         runs_ff      <= runs_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_capacity;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      ev_ff   <= ev_in;
      evid_ff <= evid_in;
      cost_ff <= cost_in;
      id_ff   <= id_in;
      if (out_load) begin
         acc_ff   <= finish;
         slotw_ff <= finish ? esrw_pkg::SLOT_W'(slot_ff) : '0;
         evv_ff   <= finish && ev_ff;
         evido_ff <= (finish && ev_ff) ? evid_ff : '0;
         wcost_ff <= esrw_pkg::COST_W'(worst_cost);
         wslot_ff <= esrw_pkg::SLOT_W'(worst_idx);
         fill_ff  <= esrw_pkg::FILL_W'(occupied_in);
         ncc_ff   <= stall_in;
         chg_ff   <= changed_in;
         mnd_ff   <= mined_in;
         mcnt_ff  <= runs_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = acc_ff;
   assign rsp_slot_written    = slotw_ff;
   assign rsp_evicted_valid   = evv_ff;
   assign rsp_evicted_id      = evido_ff;
   assign rsp_worst_cost      = wcost_ff;
   assign rsp_worst_slot      = wslot_ff;
   assign rsp_fill_count      = fill_ff;
   assign rsp_no_change_count = ncc_ff;
   assign rsp_changed_flag    = chg_ff;
   assign rsp_mined_flag      = mnd_ff;
   assign rsp_mine_count      = mcnt_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      occupied_ff <= CNT_W'(ELITE_DEPTH))
      else $error("fill count beyond table depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == esrw_pkg::ST_SCAN |-> CNT_W'(scan_idx_ff) < occupied_ff)
      else $error("rescan ran past the occupied slots");

   a_accept_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |->
         rsp_changed_flag && !rsp_mined_flag && rsp_no_change_count == '0)
      else $error("accepted item without flag update");

   a_evict_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted_valid |-> rsp_accepted)
      else $error("eviction reported on a rejected item");
`endif

endmodule
`default_nettype wire
